// ===== sv/iat_pkg.sv =====
// shared constants, types and the overlap function of the interval admission table
package iat_pkg;

   localparam int MAX_ACCEPTED = 64;
   localparam int TIME_BITS    = 16;

   // fixed field widths of the request and response channels
   localparam int START_BITS = 16;
   localparam int DUR_BITS   = 16;
   localparam int COUNT_BITS = 7;

   localparam int END_BITS = TIME_BITS + 1;
   localparam int CNT_BITS = $clog2(MAX_ACCEPTED + 1);
   localparam int IDX_BITS = (MAX_ACCEPTED > 1) ? $clog2(MAX_ACCEPTED) : 1;

   typedef struct packed {
      logic [TIME_BITS-1:0] span_start;
      logic [END_BITS-1:0]  span_end;
   } iat_entry_type;

   typedef struct packed {
      logic                wr_en;
      logic [IDX_BITS-1:0] wr_addr;
      iat_entry_type       wr_data;
      logic                rd_en;
      logic [IDX_BITS-1:0] rd_addr;
   } iat_mem_req_type;

   // touching intervals do not overlap
   function automatic logic iat_clash(input iat_entry_type a, input iat_entry_type b);
      logic a_before;
      logic b_before;
      a_before = a.span_end <= END_BITS'(b.span_start);
      b_before = b.span_end <= END_BITS'(a.span_start);
      return !(a_before || b_before);
   endfunction

endpackage

// ===== sv/iat_req_if.sv =====
// request channel: one interval per request
interface iat_req_if;
   logic                            valid;
   logic                            ready;
   logic [iat_pkg::START_BITS-1:0]  interval_start;
   logic [iat_pkg::DUR_BITS-1:0]    duration;
   logic                            last;

   modport source (output valid, interval_start, duration, last, input ready);
   modport sink   (input valid, interval_start, duration, last, output ready);
endinterface

// ===== sv/iat_rsp_if.sv =====
// response channel: admission decision and running count
interface iat_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            accepted;
   logic [iat_pkg::COUNT_BITS-1:0]  accepted_count;
   logic                            dropped_full;
   logic                            set_done;

   modport source (output valid, accepted, accepted_count, dropped_full, set_done,
                   input ready);
   modport sink   (input valid, accepted, accepted_count, dropped_full, set_done,
                   output ready);
endinterface

// ===== sv/iat_table.sv =====
// single-port-write, registered-read store of accepted intervals
module iat_table (
   input  logic                      clock,
   input  iat_pkg::iat_mem_req_type  mem_req,
   output iat_pkg::iat_entry_type    rd_data
);
   import iat_pkg::*;

   iat_entry_type mem [MAX_ACCEPTED];
   iat_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/iat_seq.sv =====
// sequencer: scans stored intervals through one overlap comparator, then decides
module iat_seq (
   input  logic                      clock,
   input  logic                      reset,
   iat_req_if.sink                   req,
   iat_rsp_if.source                 rsp,
   output iat_pkg::iat_mem_req_type  mem_req,
   input  iat_pkg::iat_entry_type    rd_data
);
   import iat_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic                rd_vld_ff, rd_vld_in;
   logic                hit_ff, hit_in;
   iat_entry_type       query_ff, query_in;
   logic                last_ff, last_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  acc_ff, acc_in;
   logic                  drop_ff, drop_in;
   logic                  done_ff, done_in;
   logic [COUNT_BITS-1:0] count_out_ff, count_out_in;

   logic                  req_fire;
   logic                  issue;
   logic                  out_free;
   logic                  room;
   logic [TIME_BITS-1:0]  q_start;
   logic [TIME_BITS-1:0]  q_dur;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign issue     = idx_ff < cnt_ff;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign room      = cnt_ff < CNT_BITS'(MAX_ACCEPTED);
   assign q_start   = TIME_BITS'(req.interval_start);
   assign q_dur     = TIME_BITS'(req.duration);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      rd_vld_in    = 1'b0;
      hit_in       = hit_ff;
      query_in     = query_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      acc_in       = acc_ff;
      drop_in      = drop_ff;
      done_in      = done_ff;
      count_out_in = count_out_ff;

      mem_req          = '0;
      mem_req.wr_addr  = cnt_ff[IDX_BITS-1:0];
      mem_req.wr_data  = query_ff;
      mem_req.rd_addr  = idx_ff[IDX_BITS-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               query_in.span_start = q_start;
               query_in.span_end   = {1'b0, q_start} + {1'b0, q_dur};
               last_in             = req.last;
               idx_in              = '0;
               hit_in              = 1'b0;
               state_in            = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               mem_req.rd_en = 1'b1;
               idx_in        = idx_ff + CNT_BITS'(1);
               rd_vld_in     = 1'b1;
            end
            // compare the entry read in the previous cycle
            if (rd_vld_ff) begin
               hit_in = hit_ff | iat_clash(query_ff, rd_data);
            end
            if (!issue && !rd_vld_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               acc_in  = 1'b0;
               drop_in = 1'b0;
               if (!hit_ff) begin
                  if (room) begin
                     mem_req.wr_en = 1'b1;
                     cnt_in        = cnt_ff + CNT_BITS'(1);
                     acc_in        = 1'b1;
                  end else begin
                     drop_in = 1'b1;
                  end
               end
               count_out_in = COUNT_BITS'(cnt_in);
               done_in      = last_ff;
               rsp_valid_in = 1'b1;
               if (last_ff) begin
                  cnt_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      hit_ff       <= hit_in;
      query_ff     <= query_in;
      last_ff      <= last_in;
      acc_ff       <= acc_in;
      drop_ff      <= drop_in;
      done_ff      <= done_in;
      count_out_ff <= count_out_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.accepted       = acc_ff;
   assign rsp.accepted_count = count_out_ff;
   assign rsp.dropped_full   = drop_ff;
   assign rsp.set_done       = done_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(MAX_ACCEPTED))
      else $error("entry count above table size");

   a_rsp_from_decide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DECIDE)
      else $error("response raised outside decision");

   a_acc_drop_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(acc_ff && drop_ff))
      else $error("accepted and dropped together");

   a_fire_scan: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_SCAN && !rd_vld_ff)
      else $error("request did not start a scan");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && out_free && last_ff) |=> cnt_ff == '0)
      else $error("table not cleared after last request");

endmodule

// ===== sv/interval_admission_table_top.sv =====
// top level of the interval admission table
//
//   channel | direction | payload
//   req     | in        | interval_start, duration, last
//   rsp     | out       | accepted, accepted_count, dropped_full, set_done
//
// a request scans the stored intervals between accept and response valid: one table
// read per cycle, each compared in the cycle after its read in a single comparator,
// then the decision.
// req is ready again in the same cycle that the response is raised, so a new
// request is taken only once the previous one has been answered.
// reset clears the entry count and handshake state; table contents need none.
// a held response stalls the decision until rsp is free; req is ready only
// when no request is in flight.
module interval_admission_table_top (
   input  logic       clock,
   input  logic       reset,
   iat_req_if.sink    req_chan,
   iat_rsp_if.source  rsp_chan
);
   import iat_pkg::*;

   iat_mem_req_type mem_req;
   iat_entry_type   rd_data;

   iat_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .rsp     (rsp_chan),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   iat_table u_table (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule
